>>> hw/rtl/psm_pkg.sv
package psm_pkg;

    localparam int SLOTS        = 20;
    localparam int STAGGER_STEP = 1;
    localparam int IDX_W        = (SLOTS > 1) ? $clog2(SLOTS) : 1;
    localparam int CNT_W        = $clog2(SLOTS + 1);
    localparam int QDEPTH       = 2;
    localparam int QPTR_W       = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
    localparam int QCNT_W       = $clog2(QDEPTH + 1);

    localparam logic [1:0] ST_OK   = 2'd0;
    localparam logic [1:0] ST_FULL = 2'd1;
    localparam logic [1:0] ST_DUE  = 2'd2;

    typedef struct packed {
        logic        is_tick;
        logic [7:0]  msg_id;
        logic [15:0] period;
        logic        enable;
        logic        packer;
        logic [31:0] now;
    } psm_cmd_t;

    typedef struct packed {
        logic [7:0]  id;
        logic        enable;
        logic [15:0] period;
        logic [31:0] stamp;
        logic        packer;
    } psm_slot_t;

    typedef struct packed {
        logic [CNT_W-1:0] slot_count;
        logic             pend_valid;
    } psm_stat_t;

endpackage

>>> hw/rtl/periodic_message_scheduler_core.sv
// Register word: slots searched one by one (at most 20) before its status word.
// Tick word: all slot_count slots looked at before its final word, one slot per cycle while
// no due word is held up by m_tready; the walker takes one word at a time, and a two-word
// queue in front (holding the word being walked) keeps s_tready up until it is full.
// Reset (rst_n, asynchronous, active low) empties the queue and the table; no clearing pass.
module periodic_message_scheduler_core
    import psm_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [63:0] s_tdata,   // msg_id[7:0], period[23:8], start_enabled[24],
                                   // has_packer[25], now_ms[57:26], zero fill
    input  logic [0:0]  s_tuser,   // cmd[0]
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [7:0]  m_tdata,   // due_id[7:0]
    output logic [1:0]  m_tuser,   // status[1:0]
    output logic        m_tlast
);

    logic       cmd_valid;
    psm_cmd_t   cmd;
    logic       cmd_pop;
    psm_stat_t  stat;

    psm_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .cmd_valid (cmd_valid),
        .cmd       (cmd),
        .cmd_pop   (cmd_pop)
    );

    psm_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd_valid (cmd_valid),
        .cmd       (cmd),
        .cmd_pop   (cmd_pop),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .m_tlast   (m_tlast),
        .stat      (stat)
    );

`ifndef NO_ASSERTIONS
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        stat.slot_count <= CNT_W'(SLOTS))
        else $error("slot count beyond table size");

    a_reg_last: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && m_tuser != ST_DUE) |-> (m_tlast && m_tdata == 8'd0))
        else $error("register status word not single and clean");

    a_status_code: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> (m_tuser == ST_OK || m_tuser == ST_FULL || m_tuser == ST_DUE))
        else $error("bad status code");

    a_pend_pop: assert property (@(posedge clk) disable iff (!rst_n)
        (stat.pend_valid && cmd_pop) |=> (m_tvalid && m_tlast))
        else $error("pending word dropped");

    a_pend_tick: assert property (@(posedge clk) disable iff (!rst_n)
        $fell(stat.pend_valid) |-> (m_tvalid && m_tlast && m_tuser == ST_DUE))
        else $error("final due word not marked last");
`endif

endmodule

>>> hw/rtl/psm_front.sv
module psm_front
    import psm_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [63:0] s_tdata,
    input  logic [0:0]  s_tuser,
    output logic        cmd_valid,
    output psm_cmd_t    cmd,
    input  logic        cmd_pop
);

    psm_cmd_t            q_mem [QDEPTH];
    logic [QPTR_W-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [QPTR_W-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [QCNT_W-1:0]   cnt_reg, cnt_next;
    logic                push;
    logic                pop;
    psm_cmd_t            in_cmd;

    // classify the incoming word
    always_comb
    begin
        in_cmd.is_tick = s_tuser[0];
        in_cmd.msg_id  = s_tdata[7:0];
        in_cmd.period  = s_tdata[23:8];
        in_cmd.enable  = s_tdata[24];
        in_cmd.packer  = s_tdata[25];
        in_cmd.now     = s_tdata[57:26];
    end

    assign s_tready  = (cnt_reg != QCNT_W'(QDEPTH));
    assign push      = s_tvalid && s_tready;
    assign cmd_valid = (cnt_reg != '0);
    assign pop       = cmd_pop && cmd_valid;
    assign cmd       = q_mem[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        cnt_next    = cnt_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == QPTR_W'(QDEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == QPTR_W'(QDEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop)
        begin
            cnt_next = cnt_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            cnt_next = cnt_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            q_mem[wr_ptr_reg] <= in_cmd;
        end
    end

endmodule

>>> hw/rtl/psm_back.sv
module psm_back
    import psm_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cmd_valid,
    input  psm_cmd_t    cmd,
    output logic        cmd_pop,
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [7:0]  m_tdata,
    output logic [1:0]  m_tuser,
    output logic        m_tlast,
    output psm_stat_t   stat
);

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_REG  = 2'd1;
    localparam logic [1:0] S_TICK = 2'd2;

    psm_slot_t          slot_mem [SLOTS];
    logic [1:0]         state_reg, state_next;
    logic [CNT_W-1:0]   idx_reg, idx_next;
    logic [CNT_W-1:0]   count_reg, count_next;
    logic               pend_valid_reg, pend_valid_next;
    logic [7:0]         pend_id_reg, pend_id_next;
    logic               out_valid_reg, out_valid_next;
    logic [1:0]         out_status_reg, out_status_next;
    logic [7:0]         out_id_reg, out_id_next;
    logic               out_last_reg, out_last_next;

    logic               out_free;
    logic               in_range;
    psm_slot_t          rd_slot;
    logic [31:0]        diff;
    logic               due;
    logic [31:0]        reg_stamp;
    logic               wr_en;
    logic [IDX_W-1:0]   wr_addr;
    psm_slot_t          wr_data;
    psm_slot_t          new_slot;

    assign out_free = !out_valid_reg || m_tready;
    assign in_range = (idx_reg < count_reg);
    assign rd_slot  = slot_mem[idx_reg[IDX_W-1:0]];
    assign diff     = cmd.now - rd_slot.stamp;
    assign due      = rd_slot.enable && rd_slot.packer && !diff[31]
                      && (diff >= {16'd0, rd_slot.period});
    assign reg_stamp = cmd.now + 32'(count_reg) * 32'(STAGGER_STEP);

    always_comb
    begin
        new_slot.id     = cmd.msg_id;
        new_slot.enable = cmd.enable;
        new_slot.period = cmd.period;
        new_slot.stamp  = reg_stamp;
        new_slot.packer = cmd.packer;
    end

    always_comb
    begin
        state_next      = state_reg;
        idx_next        = idx_reg;
        count_next      = count_reg;
        pend_valid_next = pend_valid_reg;
        pend_id_next    = pend_id_reg;
        out_valid_next  = out_valid_reg && !m_tready;
        out_status_next = out_status_reg;
        out_id_next     = out_id_reg;
        out_last_next   = out_last_reg;
        cmd_pop         = 1'b0;
        wr_en           = 1'b0;
        wr_addr         = idx_reg[IDX_W-1:0];
        wr_data         = new_slot;

        case (state_reg)
            S_IDLE:
            begin
                if (cmd_valid)
                begin
                    idx_next   = '0;
                    state_next = cmd.is_tick ? S_TICK : S_REG;
                end
            end
            S_REG:
            begin
                if (in_range && rd_slot.id != cmd.msg_id)
                begin
                    idx_next = idx_reg + 1'b1;
                end
                else if (out_free)
                begin
                    out_valid_next  = 1'b1;
                    out_id_next     = 8'd0;
                    out_last_next   = 1'b1;
                    out_status_next = ST_OK;
                    cmd_pop         = 1'b1;
                    state_next      = S_IDLE;
                    if (in_range)
                    begin
                        wr_en = 1'b1;
                    end
                    else if (count_reg == CNT_W'(SLOTS))
                    begin
                        out_status_next = ST_FULL;
                    end
                    else
                    begin
                        wr_en      = 1'b1;
                        count_next = count_reg + 1'b1;
                    end
                end
            end
            S_TICK:
            begin
                if (in_range)
                begin
                    if (!due)
                    begin
                        idx_next = idx_reg + 1'b1;
                    end
                    else if (!pend_valid_reg || out_free)
                    begin
                        wr_en         = 1'b1;
                        wr_data       = rd_slot;
                        wr_data.stamp = cmd.now;
                        if (pend_valid_reg)
                        begin
                            out_valid_next  = 1'b1;
                            out_status_next = ST_DUE;
                            out_id_next     = pend_id_reg;
                            out_last_next   = 1'b0;
                        end
                        pend_valid_next = 1'b1;
                        pend_id_next    = rd_slot.id;
                        idx_next        = idx_reg + 1'b1;
                    end
                end
                else if (!pend_valid_reg)
                begin
                    cmd_pop    = 1'b1;
                    state_next = S_IDLE;
                end
                else if (out_free)
                begin
                    // hold-back word goes out last
                    out_valid_next  = 1'b1;
                    out_status_next = ST_DUE;
                    out_id_next     = pend_id_reg;
                    out_last_next   = 1'b1;
                    pend_valid_next = 1'b0;
                    cmd_pop         = 1'b1;
                    state_next      = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            idx_reg        <= '0;
            count_reg      <= '0;
            pend_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            idx_reg        <= idx_next;
            count_reg      <= count_next;
            pend_valid_reg <= pend_valid_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        pend_id_reg    <= pend_id_next;
        out_status_reg <= out_status_next;
        out_id_reg     <= out_id_next;
        out_last_reg   <= out_last_next;
        if (wr_en)
        begin
            slot_mem[wr_addr] <= wr_data;
        end
    end

    assign m_tvalid        = out_valid_reg;
    assign m_tdata         = out_id_reg;
    assign m_tuser         = out_status_reg;
    assign m_tlast         = out_last_reg;
    assign stat.slot_count = count_reg;
    assign stat.pend_valid = pend_valid_reg;

endmodule
